// ===== hw/rtl/button_debounce_long_press_repeat_unit_defines.svh =====
// Assertion macros shared by the button debounce RTL.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define BDLPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define BDLPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bdlpr_pkg.sv =====
// Types and constants of the button debounce, long press and auto-repeat unit.
package bdlpr_pkg;

	localparam int TIME_W = 32;
	localparam int CFG_W  = 16;
	localparam int BTN_W  = 3;
	localparam int IDX_W  = 2;

	typedef logic [TIME_W-1:0] time_ms_t;
	typedef logic [CFG_W-1:0]  cfg_ms_t;
	typedef logic [BTN_W-1:0]  btn_t;
	typedef logic [IDX_W-1:0]  cfg_idx_t;

	// Raw button codes.
	localparam btn_t KEY_NONE   = 3'd0;
	localparam btn_t KEY_RIGHT  = 3'd1;
	localparam btn_t KEY_UP     = 3'd2;
	localparam btn_t KEY_DOWN   = 3'd3;
	localparam btn_t KEY_LEFT   = 3'd4;
	localparam btn_t KEY_SELECT = 3'd5;

	// Event codes; the direction events share the button codes.
	localparam btn_t EV_NONE         = 3'd0;
	localparam btn_t EV_SELECT_SHORT = 3'd5;
	localparam btn_t EV_SELECT_HELD  = 3'd6;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_DEBOUNCE     = 2'd0;
	localparam cfg_idx_t CFG_LONG_PRESS   = 2'd1;
	localparam cfg_idx_t CFG_REPEAT_DELAY = 2'd2;
	localparam cfg_idx_t CFG_REPEAT_PERIOD = 2'd3;

	// Configuration reset values in milliseconds.
	localparam cfg_ms_t DEBOUNCE_RST      = 16'd50;
	localparam cfg_ms_t LONG_PRESS_RST    = 16'd1000;
	localparam cfg_ms_t REPEAT_DELAY_RST  = 16'd500;
	localparam cfg_ms_t REPEAT_PERIOD_RST = 16'd150;

	// Configuration register set.
	typedef struct packed {
		cfg_ms_t debounce;
		cfg_ms_t long_press;
		cfg_ms_t repeat_delay;
		cfg_ms_t repeat_period;
	} cfg_regs_t;

endpackage

// ===== hw/rtl/button_debounce_long_press_repeat_unit.sv =====
// Button debouncer with select short/long press and up/down auto-repeat.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  poll     | in        | in_valid/in_stall  | sample_time_ms, raw_button, arm_release
//  event    | out       | out_valid/out_stall| event_code
//  config   | in        | cfg_we             | cfg_index, cfg_data
//
// Each poll request is registered in stage one, evaluated against the button state
// combinationally and written with the state update into the output register; one
// poll per cycle is sustained while the event output is not stalled. The poll register
// empties into the output register whenever that is empty or being taken, so a stalled
// event still lets one further poll be captured. Reset loads the register defaults and
// clears the button state and valid flags; it takes effect at once with no clearing pass.
module button_debounce_long_press_repeat_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  bdlpr_pkg::time_ms_t     sample_time_ms,
	input  bdlpr_pkg::btn_t         raw_button,
	input  logic                    arm_release,
	output logic                    out_valid,
	input  logic                    out_stall,
	output bdlpr_pkg::btn_t         event_code,
	input  logic                    cfg_we,
	input  bdlpr_pkg::cfg_idx_t     cfg_index,
	input  bdlpr_pkg::cfg_ms_t      cfg_data
);

	import bdlpr_pkg::*;

	`include "button_debounce_long_press_repeat_unit_defines.svh"

	cfg_regs_t cfg_q;

	// Poll register.
	logic     valid_s1;
	time_ms_t now_s1;
	btn_t     raw_s1;
	logic     arm_s1;

	// Button state.
	btn_t     prev_raw_q;
	btn_t     deb_btn_q;
	time_ms_t change_time_q;
	time_ms_t hold_start_q;
	time_ms_t repeat_time_q;
	logic     long_done_q;
	logic     await_q;

	// Output register.
	logic     out_valid_q;
	btn_t     event_q;

	// Next state and event.
	btn_t     prev_raw_d;
	btn_t     deb_btn_d;
	time_ms_t change_time_d;
	time_ms_t hold_start_d;
	time_ms_t repeat_time_d;
	logic     long_done_d;
	logic     await_d;
	logic     await_eff;
	btn_t     ev_d;

	time_ms_t since_change;
	time_ms_t since_hold;
	time_ms_t since_repeat;
	logic     debounce_met;
	logic     long_met;
	logic     delay_met;
	logic     period_met;

	logic     in_take;
	logic     adv;

	// Handshake: the poll register moves on when the output register is free.
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign event_code = event_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce      <= DEBOUNCE_RST;
			cfg_q.long_press    <= LONG_PRESS_RST;
			cfg_q.repeat_delay  <= REPEAT_DELAY_RST;
			cfg_q.repeat_period <= REPEAT_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:      cfg_q.debounce      <= cfg_data;
				CFG_LONG_PRESS:    cfg_q.long_press    <= cfg_data;
				CFG_REPEAT_DELAY:  cfg_q.repeat_delay  <= cfg_data;
				CFG_REPEAT_PERIOD: cfg_q.repeat_period <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// Poll register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Poll payload; codes six and seven count as no button.
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_s1 <= sample_time_ms;
			raw_s1 <= (raw_button > KEY_SELECT) ? KEY_NONE : raw_button;
			arm_s1 <= arm_release;
		end
	end

	// Elapsed times, all modulo 2^32.
	assign since_change = now_s1 - change_time_q;
	assign since_hold   = now_s1 - hold_start_q;
	assign since_repeat = now_s1 - repeat_time_q;
	assign debounce_met = since_change >= {{(TIME_W-CFG_W){1'b0}}, cfg_q.debounce};
	assign long_met     = since_hold   >= {{(TIME_W-CFG_W){1'b0}}, cfg_q.long_press};
	assign delay_met    = since_hold   >= {{(TIME_W-CFG_W){1'b0}}, cfg_q.repeat_delay};
	assign period_met   = since_repeat >= {{(TIME_W-CFG_W){1'b0}}, cfg_q.repeat_period};
	assign await_eff    = await_q || arm_s1;

	// Evaluation of one poll against the button state.
	always_comb begin
		prev_raw_d    = prev_raw_q;
		deb_btn_d     = deb_btn_q;
		change_time_d = change_time_q;
		hold_start_d  = hold_start_q;
		repeat_time_d = repeat_time_q;
		long_done_d   = long_done_q;
		await_d       = await_eff;
		ev_d          = EV_NONE;
		if (await_eff) begin
			// Nothing is reported until no button has stayed debounced.
			if (raw_s1 != prev_raw_q) begin
				prev_raw_d    = raw_s1;
				change_time_d = now_s1;
			end else if (raw_s1 != KEY_NONE) begin
				change_time_d = now_s1;
			end else if (debounce_met) begin
				await_d     = 1'b0;
				deb_btn_d   = KEY_NONE;
				long_done_d = 1'b0;
			end
		end else if (raw_s1 != prev_raw_q) begin
			prev_raw_d    = raw_s1;
			change_time_d = now_s1;
		end else if (!debounce_met) begin
			ev_d = EV_NONE;
		end else if (raw_s1 != deb_btn_q) begin
			// A debounced change: press edges of the direction keys, select on release.
			deb_btn_d     = raw_s1;
			hold_start_d  = now_s1;
			repeat_time_d = now_s1;
			long_done_d   = 1'b0;
			if (raw_s1 == KEY_NONE) begin
				if (deb_btn_q == KEY_SELECT && !long_done_q) begin
					ev_d = EV_SELECT_SHORT;
				end
			end else if (raw_s1 != KEY_SELECT) begin
				ev_d = raw_s1;
			end
		end else if (deb_btn_q == KEY_SELECT && !long_done_q && long_met) begin
			long_done_d = 1'b1;
			ev_d        = EV_SELECT_HELD;
		end else if ((deb_btn_q == KEY_UP || deb_btn_q == KEY_DOWN) &&
				delay_met && period_met) begin
			repeat_time_d = now_s1;
			ev_d          = deb_btn_q;
		end
	end

	// Button state update, one poll at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q    <= KEY_NONE;
			deb_btn_q     <= KEY_NONE;
			change_time_q <= '0;
			hold_start_q  <= '0;
			repeat_time_q <= '0;
			long_done_q   <= 1'b0;
			await_q       <= 1'b0;
		end else if (adv) begin
			prev_raw_q    <= prev_raw_d;
			deb_btn_q     <= deb_btn_d;
			change_time_q <= change_time_d;
			hold_start_q  <= hold_start_d;
			repeat_time_q <= repeat_time_d;
			long_done_q   <= long_done_d;
			await_q       <= await_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output event payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			event_q <= ev_d;
		end
	end

	// A poll is held back only while the output register is full and stalled.
	`BDLPR_ASSERT_NOW(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall, "in_stall without a blocked output")
	// No event is given while release is awaited.
	`BDLPR_ASSERT_NOW(a_await_quiet, adv && await_eff, ev_d == EV_NONE, "event while awaiting release")
	// A long select event leaves the long press marked as done.
	`BDLPR_ASSERT_NEXT(a_long_marks, adv && ev_d == EV_SELECT_HELD, long_done_q, "long press not marked")
	// Every up or down event restarts the repeat spacing at the poll time.
	`BDLPR_ASSERT_NEXT(a_repeat_time, adv && (ev_d == KEY_UP || ev_d == KEY_DOWN), repeat_time_q == $past(now_s1), "repeat time not restarted")

endmodule
